// ----- rtl/core/cable_arm_impedance_controller_assert.svh -----
// Assertion macros for the checker file of the impedance controller.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CABLE_ARM_IMPEDANCE_CONTROLLER_ASSERT_SVH
`define CABLE_ARM_IMPEDANCE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CAIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CAIC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/caic_pkg.sv -----
package caic_pkg;

	// Field and datapath widths.
	localparam int RAW_W  = 24;   // Q7.16 input fields
	localparam int ANG_W  = 25;   // offset-corrected motor angle or rate
	localparam int TH_W   = 32;   // joint angle or rate, scaled by 120
	localparam int ERR_W  = 33;   // joint error against the target
	localparam int GAIN_W = 16;   // Q8.8 gains
	localparam int CUR_W  = 15;   // Q5.10 current limits
	localparam int TQ_W   = 50;   // joint torque
	localparam int F_W    = 55;   // motor current before the base is added
	localparam int BASE_W = 56;   // coactivation base
	localparam int TGT_W  = 57;   // current with the base added
	localparam int T_W    = 41;   // clamped current, never negative
	localparam int NUM_W  = 46;   // rounding numerator
	localparam int X_W    = 25;   // numerator after the power-of-two part
	localparam int MAG_W  = 26;   // reciprocal constants
	localparam int MUL_W  = X_W + MAG_W;
	localparam int Q_W    = MUL_W - 33;
	localparam int DRV_W  = 16;

	localparam int NJ   = 3;
	localparam int NM   = 4;
	localparam int NSTG = 12;

	localparam int IN_DATA_W  = 11 * RAW_W;
	localparam int OUT_DATA_W = NM * DRV_W;

	// Internal current scale is 3600 * 2^14 units per Q5.10 step.
	localparam logic [T_W-1:0]   CUR_DEN = T_W'(58982400);
	localparam logic [NUM_W-1:0] DEN_X1  = NUM_W'(58982400);
	localparam logic [NUM_W-1:0] DEN_X5  = NUM_W'(5 * 58982400);
	localparam logic [NUM_W-1:0] DEN_X10 = NUM_W'(10 * 58982400);

	// Exact reciprocals for numerators below 2^25: ceil(2^33/225), ceil(2^36/1125).
	localparam logic [MAG_W-1:0] MAGIC_225  = MAG_W'(38177488);
	localparam logic [MAG_W-1:0] MAGIC_1125 = MAG_W'(61083980);

	localparam logic [CUR_W-1:0] Q_MAX = {CUR_W{1'b1}};

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD0  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KD1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD2  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MINC = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAXC = 3'd7;

	localparam logic [GAIN_W-1:0] KP0_RST  = 16'd2304;
	localparam logic [GAIN_W-1:0] KP1_RST  = 16'd1536;
	localparam logic [GAIN_W-1:0] KP2_RST  = 16'd26;
	localparam logic [GAIN_W-1:0] KD0_RST  = 16'd410;
	localparam logic [GAIN_W-1:0] KD1_RST  = 16'd307;
	localparam logic [GAIN_W-1:0] KD2_RST  = 16'd205;
	localparam logic [CUR_W-1:0]  MINC_RST = 15'd614;
	localparam logic [CUR_W-1:0]  MAXC_RST = 15'd9216;

	// Output scaling of each motor: gain 0.6, 1, -1 and -0.9.
	typedef enum logic [1:0] {
		DRV_P06,
		DRV_P10,
		DRV_N10,
		DRV_N09
	} drv_kind_t;

	localparam drv_kind_t DRV_KIND [NM] = '{DRV_P06, DRV_P10, DRV_N10, DRV_N09};

	// Stage load enables handed to the lanes.
	typedef struct packed {
		logic err;
		logic prod;
		logic sum;
	} joint_ld_t;

	typedef struct packed {
		logic clamp;
		logic scale;
		logic mult;
		logic drv;
	} motor_ld_t;

endpackage

// ----- rtl/core/cable_arm_impedance_controller.sv -----
// Channel   | Direction | Handshake                     | Content
// s_axis    | in        | s_axis_tvalid / s_axis_tready | motor angles, rates, targets, capture
// m_axis    | out       | m_axis_tvalid / m_axis_tready | four motor drive currents
// cfg       | in        | cfg_valid / cfg_ready         | register index and write data
//
// One word is taken per clock unless every stage is full and m_axis stalls, and
// one drive word returns per input word. Stages: input, geometry, joint error, the
// joint gain multipliers, torque sum, current merge, minimum, base, then each motor
// lane's clamp, scale, reciprocal multiply and drive. A stall on m_axis halts a stage
// only when it and every later stage are full; the others keep taking words, and the
// last stage serves as the output register. Reset clears the stage valid bits and zero
// offsets and sets the gain and limit defaults; no clearing pass is needed.
module cable_arm_impedance_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// From bit 0 up: raw_angle0..3, raw_rate0..3, goal_joint0..2, 24 bits each.
	input  logic [caic_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// zero_capture.
	input  logic                                  s_axis_tuser,

	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// From bit 0 up: drive0, drive1, drive2, drive3, 16 bits each.
	output logic [caic_pkg::OUT_DATA_W-1:0]       m_axis_tdata,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [caic_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [caic_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Stage numbering: index 0 is the first pipeline stage.
	localparam int ST_IN   = 0;
	localparam int ST_GEO  = 1;
	localparam int ST_ERR  = 2;
	localparam int ST_PROD = 3;
	localparam int ST_SUM  = 4;
	localparam int ST_F    = 5;
	localparam int ST_PMIN = 6;
	localparam int ST_BASE = 7;
	localparam int ST_CLMP = 8;
	localparam int ST_SCL  = 9;
	localparam int ST_MULT = 10;
	localparam int ST_DRV  = 11;

	// Configuration registers.
	logic [caic_pkg::GAIN_W-1:0] kp_q [caic_pkg::NJ];
	logic [caic_pkg::GAIN_W-1:0] kd_q [caic_pkg::NJ];
	logic [caic_pkg::CUR_W-1:0]  min_cur_q;
	logic [caic_pkg::CUR_W-1:0]  max_cur_q;
	logic [caic_pkg::T_W-1:0]    mc_q;
	logic [caic_pkg::T_W-1:0]    mx_q;

	// Pipeline control.
	logic [caic_pkg::NSTG-1:0] vld_q;
	logic [caic_pkg::NSTG-1:0] ld;
	logic [caic_pkg::NSTG-1:0] vld_in;
	logic                      accept;

	// Input fields and zero offsets.
	logic signed [caic_pkg::RAW_W-1:0] raw   [caic_pkg::NM];
	logic signed [caic_pkg::RAW_W-1:0] rate  [caic_pkg::NM];
	logic signed [caic_pkg::RAW_W-1:0] goal  [caic_pkg::NJ];
	logic signed [caic_pkg::RAW_W-1:0] off_q [caic_pkg::NM];
	logic signed [caic_pkg::ANG_W-1:0] ang   [caic_pkg::NM];
	logic signed [caic_pkg::ANG_W-1:0] vel   [caic_pkg::NM];

	logic signed [caic_pkg::ANG_W-1:0] ang_s1  [caic_pkg::NM];
	logic signed [caic_pkg::ANG_W-1:0] vel_s1  [caic_pkg::NM];
	logic signed [caic_pkg::RAW_W-1:0] goal_s1 [caic_pkg::NJ];

	logic [caic_pkg::NJ*caic_pkg::TH_W-1:0] th_vec;
	logic [caic_pkg::NJ*caic_pkg::TH_W-1:0] tv_vec;
	logic signed [caic_pkg::TH_W-1:0]  th_s2   [caic_pkg::NJ];
	logic signed [caic_pkg::TH_W-1:0]  tv_s2   [caic_pkg::NJ];
	logic signed [caic_pkg::RAW_W-1:0] goal_s2 [caic_pkg::NJ];

	caic_pkg::joint_ld_t               jld;
	logic signed [caic_pkg::TQ_W-1:0]  tq [caic_pkg::NJ];

	logic signed [caic_pkg::F_W-1:0]   tq_x [caic_pkg::NJ];
	logic signed [caic_pkg::F_W-1:0]   f_s6 [caic_pkg::NM];
	logic signed [caic_pkg::F_W-1:0]   f_s7 [caic_pkg::NM];
	logic signed [caic_pkg::F_W-1:0]   m01_s7;
	logic signed [caic_pkg::F_W-1:0]   m23_s7;
	logic signed [caic_pkg::F_W-1:0]   f_s8 [caic_pkg::NM];
	logic signed [caic_pkg::F_W-1:0]   f_min;
	logic signed [caic_pkg::BASE_W-1:0] diff;
	logic signed [caic_pkg::BASE_W-1:0] base_s8;

	caic_pkg::motor_ld_t                mld;
	logic signed [caic_pkg::DRV_W-1:0]  drive [caic_pkg::NM];

	// Cable geometry. Joint values come out scaled by 120:
	// theta0 = 7(a0+a1-a2-a3), theta1 = 14(a2-a3), theta2 = 28(a0-a1-a2+a3).
	function automatic logic [caic_pkg::NJ*caic_pkg::TH_W-1:0] to_joint(
		input logic signed [caic_pkg::ANG_W-1:0] m0,
		input logic signed [caic_pkg::ANG_W-1:0] m1,
		input logic signed [caic_pkg::ANG_W-1:0] m2,
		input logic signed [caic_pkg::ANG_W-1:0] m3
	);
		logic signed [caic_pkg::TH_W-1:0] c0;
		logic signed [caic_pkg::TH_W-1:0] c1;
		logic signed [caic_pkg::TH_W-1:0] c2;
		c0 = caic_pkg::TH_W'(m0) + caic_pkg::TH_W'(m1) - caic_pkg::TH_W'(m2)
			- caic_pkg::TH_W'(m3);
		c1 = caic_pkg::TH_W'(m2) - caic_pkg::TH_W'(m3);
		c2 = caic_pkg::TH_W'(m0) - caic_pkg::TH_W'(m1) - caic_pkg::TH_W'(m2)
			+ caic_pkg::TH_W'(m3);
		return {(c2 <<< 5) - (c2 <<< 2), (c1 <<< 4) - (c1 <<< 1), (c0 <<< 3) - c0};
	endfunction

	// ------------------------------------------------------------------
	// Configuration. Writes are always taken; the port never stalls.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q[0]   <= caic_pkg::KP0_RST;
			kp_q[1]   <= caic_pkg::KP1_RST;
			kp_q[2]   <= caic_pkg::KP2_RST;
			kd_q[0]   <= caic_pkg::KD0_RST;
			kd_q[1]   <= caic_pkg::KD1_RST;
			kd_q[2]   <= caic_pkg::KD2_RST;
			min_cur_q <= caic_pkg::MINC_RST;
			max_cur_q <= caic_pkg::MAXC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				caic_pkg::REG_KP0:  kp_q[0]   <= cfg_data;
				caic_pkg::REG_KP1:  kp_q[1]   <= cfg_data;
				caic_pkg::REG_KP2:  kp_q[2]   <= cfg_data;
				caic_pkg::REG_KD0:  kd_q[0]   <= cfg_data;
				caic_pkg::REG_KD1:  kd_q[1]   <= cfg_data;
				caic_pkg::REG_KD2:  kd_q[2]   <= cfg_data;
				caic_pkg::REG_MINC: min_cur_q <= cfg_data[caic_pkg::CUR_W-1:0];
				caic_pkg::REG_MAXC: max_cur_q <= cfg_data[caic_pkg::CUR_W-1:0];
				default: ;
			endcase
		end
	end

	// The current limits in the internal scale, registered to keep the constant multiply
	// off the merge path. The user must keep configuration changes to idle; nothing enforces it.
	always_ff @(posedge clk) begin
		mc_q <= caic_pkg::T_W'(min_cur_q) * caic_pkg::CUR_DEN;
		mx_q <= caic_pkg::T_W'(max_cur_q) * caic_pkg::CUR_DEN;
	end

	// ------------------------------------------------------------------
	// Pipeline control. A stage loads when it or any later stage is empty,
	// or when the output word is being taken.
	// ------------------------------------------------------------------
	always_comb begin
		logic [caic_pkg::NSTG-1:0] low_mask;
		low_mask = '0;
		for (int k = 0; k < caic_pkg::NSTG; k++) begin
			low_mask = (caic_pkg::NSTG'(1) << k) - caic_pkg::NSTG'(1);
			ld[k]    = m_axis_tready || !(&(vld_q | low_mask));
		end
	end

	assign vld_in = {vld_q[caic_pkg::NSTG-2:0], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (ld & vld_in) | (~ld & vld_q);
		end
	end

	assign s_axis_tready = ld[ST_IN];
	assign m_axis_tvalid = vld_q[ST_DRV];
	assign accept        = s_axis_tvalid && ld[ST_IN];

	// ------------------------------------------------------------------
	// Input stage: unpack, capture offsets, remove them, flip motors 0 and 1.
	// A capturing word uses its own raw angles as the offsets.
	// ------------------------------------------------------------------
	always_comb begin
		logic signed [caic_pkg::RAW_W-1:0] off_eff;
		off_eff = '0;
		for (int i = 0; i < caic_pkg::NM; i++) begin
			raw[i]  = $signed(s_axis_tdata[i*caic_pkg::RAW_W +: caic_pkg::RAW_W]);
			rate[i] = $signed(s_axis_tdata[(caic_pkg::NM+i)*caic_pkg::RAW_W +:
				caic_pkg::RAW_W]);
			off_eff = s_axis_tuser ? raw[i] : off_q[i];
			if (i < 2) begin
				ang[i] = caic_pkg::ANG_W'(off_eff) - caic_pkg::ANG_W'(raw[i]);
				vel[i] = -caic_pkg::ANG_W'(rate[i]);
			end else begin
				ang[i] = caic_pkg::ANG_W'(raw[i]) - caic_pkg::ANG_W'(off_eff);
				vel[i] = caic_pkg::ANG_W'(rate[i]);
			end
		end
		for (int j = 0; j < caic_pkg::NJ; j++) begin
			goal[j] = $signed(s_axis_tdata[(2*caic_pkg::NM+j)*caic_pkg::RAW_W +:
				caic_pkg::RAW_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < caic_pkg::NM; i++) begin
				off_q[i] <= '0;
			end
		end else if (accept && s_axis_tuser) begin
			for (int i = 0; i < caic_pkg::NM; i++) begin
				off_q[i] <= raw[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_IN]) begin
			ang_s1  <= ang;
			vel_s1  <= vel;
			goal_s1 <= goal;
		end
	end

	// ------------------------------------------------------------------
	// Geometry stage: motor space to joint space for angles and rates.
	// ------------------------------------------------------------------
	assign th_vec = to_joint(ang_s1[0], ang_s1[1], ang_s1[2], ang_s1[3]);
	assign tv_vec = to_joint(vel_s1[0], vel_s1[1], vel_s1[2], vel_s1[3]);

	always_ff @(posedge clk) begin
		if (ld[ST_GEO]) begin
			for (int j = 0; j < caic_pkg::NJ; j++) begin
				th_s2[j] <= $signed(th_vec[j*caic_pkg::TH_W +: caic_pkg::TH_W]);
				tv_s2[j] <= $signed(tv_vec[j*caic_pkg::TH_W +: caic_pkg::TH_W]);
			end
			goal_s2 <= goal_s1;
		end
	end

	// ------------------------------------------------------------------
	// Joint lanes: one PD law per joint, side by side.
	// ------------------------------------------------------------------
	assign jld.err  = ld[ST_ERR];
	assign jld.prod = ld[ST_PROD];
	assign jld.sum  = ld[ST_SUM];

	for (genvar j = 0; j < caic_pkg::NJ; j++) begin : g_joint
		caic_joint_lane u_joint (
			.clk  (clk),
			.ld   (jld),
			.th   (th_s2[j]),
			.rate (tv_s2[j]),
			.goal (goal_s2[j]),
			.kp   (kp_q[j]),
			.kd   (kd_q[j]),
			.tq   (tq[j])
		);
	end

	// ------------------------------------------------------------------
	// Merge: joint torques back to the four cable currents, then the
	// coactivation base |min(f) - min_current| shared by all motors.
	// ------------------------------------------------------------------
	always_comb begin
		for (int j = 0; j < caic_pkg::NJ; j++) begin
			tq_x[j] = caic_pkg::F_W'(tq[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[ST_F]) begin
			// 7*tau0 +/- 14*tau2 and -7*tau0 +/- 7*tau1, as shifts and adds.
			f_s6[0] <= (tq_x[0] <<< 3) - tq_x[0] + (tq_x[2] <<< 4) - (tq_x[2] <<< 1);
			f_s6[1] <= (tq_x[0] <<< 3) - tq_x[0] - (tq_x[2] <<< 4) + (tq_x[2] <<< 1);
			f_s6[2] <= tq_x[0] - (tq_x[0] <<< 3) + (tq_x[1] <<< 3) - tq_x[1];
			f_s6[3] <= tq_x[0] - (tq_x[0] <<< 3) - (tq_x[1] <<< 3) + tq_x[1];
		end
		if (ld[ST_PMIN]) begin
			f_s7   <= f_s6;
			m01_s7 <= (f_s6[1] < f_s6[0]) ? f_s6[1] : f_s6[0];
			m23_s7 <= (f_s6[3] < f_s6[2]) ? f_s6[3] : f_s6[2];
		end
	end

	assign f_min = (m23_s7 < m01_s7) ? m23_s7 : m01_s7;
	assign diff  = caic_pkg::BASE_W'(f_min) - $signed(caic_pkg::BASE_W'(mc_q));

	always_ff @(posedge clk) begin
		if (ld[ST_BASE]) begin
			f_s8    <= f_s7;
			base_s8 <= (diff < 0) ? -diff : diff;
		end
	end

	// ------------------------------------------------------------------
	// Motor lanes: clamp and scale each current to its drive word.
	// ------------------------------------------------------------------
	assign mld.clamp = ld[ST_CLMP];
	assign mld.scale = ld[ST_SCL];
	assign mld.mult  = ld[ST_MULT];
	assign mld.drv   = ld[ST_DRV];

	for (genvar m = 0; m < caic_pkg::NM; m++) begin : g_motor
		caic_motor_lane u_motor (
			.clk   (clk),
			.ld    (mld),
			.kind  (caic_pkg::DRV_KIND[m]),
			.f     (f_s8[m]),
			.base  (base_s8),
			.mx    (mx_q),
			.drive (drive[m])
		);
		assign m_axis_tdata[m*caic_pkg::DRV_W +: caic_pkg::DRV_W] = drive[m];
	end

endmodule

// ----- rtl/core/caic_joint_lane.sv -----
// One joint of the PD law: error, the two gain products, and their sum.
module caic_joint_lane (
	input  logic                                 clk,
	input  caic_pkg::joint_ld_t                  ld,
	input  logic signed [caic_pkg::TH_W-1:0]     th,
	input  logic signed [caic_pkg::TH_W-1:0]     rate,
	input  logic signed [caic_pkg::RAW_W-1:0]    goal,
	input  logic        [caic_pkg::GAIN_W-1:0]   kp,
	input  logic        [caic_pkg::GAIN_W-1:0]   kd,
	output logic signed [caic_pkg::TQ_W-1:0]     tq
);

	logic signed [caic_pkg::ERR_W-1:0] goal_x;
	logic signed [caic_pkg::ERR_W-1:0] goal120;
	logic signed [caic_pkg::ERR_W-1:0] err_s3;
	logic signed [caic_pkg::TH_W-1:0]  rate_s3;
	logic signed [caic_pkg::TQ_W-1:0]  p_s4;
	logic signed [caic_pkg::TQ_W-1:0]  d_s4;
	logic signed [caic_pkg::TQ_W-1:0]  tq_s5;

	// The joint angle arrives scaled by 120, so the target is scaled to match.
	assign goal_x  = caic_pkg::ERR_W'(goal);
	assign goal120 = (goal_x <<< 7) - (goal_x <<< 3);

	always_ff @(posedge clk) begin
		if (ld.err) begin
			err_s3  <= caic_pkg::ERR_W'(th) - goal120;
			rate_s3 <= rate;
		end
		if (ld.prod) begin
			p_s4 <= caic_pkg::TQ_W'($signed({1'b0, kp})) * caic_pkg::TQ_W'(err_s3);
			d_s4 <= caic_pkg::TQ_W'($signed({1'b0, kd})) * caic_pkg::TQ_W'(rate_s3);
		end
		if (ld.sum) begin
			tq_s5 <= p_s4 + d_s4;
		end
	end

	assign tq = tq_s5;

endmodule

// ----- rtl/core/caic_motor_lane.sv -----
// One motor output: add the base, clamp, then scale to Q5.10 with rounding.
module caic_motor_lane (
	input  logic                                 clk,
	input  caic_pkg::motor_ld_t                  ld,
	input  caic_pkg::drv_kind_t                  kind,
	input  logic signed [caic_pkg::F_W-1:0]      f,
	input  logic signed [caic_pkg::BASE_W-1:0]   base,
	input  logic        [caic_pkg::T_W-1:0]      mx,
	output logic signed [caic_pkg::DRV_W-1:0]    drive
);

	logic signed [caic_pkg::TGT_W-1:0] tgt;
	logic        [caic_pkg::T_W-1:0]   t_s9;
	logic        [caic_pkg::NUM_W-1:0] t_x;
	logic        [caic_pkg::NUM_W-1:0] num;
	logic        [caic_pkg::X_W-1:0]   x;
	logic        [caic_pkg::X_W-1:0]   x_s10;
	logic        [caic_pkg::MAG_W-1:0] mag;
	logic        [caic_pkg::MUL_W-1:0] prod_s11;
	logic        [caic_pkg::Q_W-1:0]   q;
	logic        [caic_pkg::CUR_W-1:0] q_sat;
	logic signed [caic_pkg::DRV_W-1:0] q_mag;
	logic                              neg;
	logic signed [caic_pkg::DRV_W-1:0] drive_s12;

	assign tgt = caic_pkg::TGT_W'(f) + caic_pkg::TGT_W'(base);

	always_ff @(posedge clk) begin
		if (ld.clamp) begin
			if (tgt < 0) begin
				t_s9 <= '0;
			end else if (tgt > $signed(caic_pkg::TGT_W'(mx))) begin
				t_s9 <= mx;
			end else begin
				t_s9 <= tgt[caic_pkg::T_W-1:0];
			end
		end
	end

	// Round-half-up numerator; the power-of-two part of the divisor is a shift.
	assign t_x = caic_pkg::NUM_W'(t_s9);

	always_comb begin
		unique case (kind)
			caic_pkg::DRV_P06: begin
				num = (t_x << 2) + (t_x << 1) + caic_pkg::DEN_X5;
				x   = caic_pkg::X_W'(num >> 19);
			end
			caic_pkg::DRV_P10, caic_pkg::DRV_N10: begin
				num = (t_x << 1) + caic_pkg::DEN_X1;
				x   = caic_pkg::X_W'(num >> 19);
			end
			caic_pkg::DRV_N09: begin
				num = (t_x << 4) + (t_x << 1) + caic_pkg::DEN_X10;
				x   = caic_pkg::X_W'(num >> 20);
			end
			default: begin
				num = '0;
				x   = '0;
			end
		endcase
	end

	assign mag = (kind == caic_pkg::DRV_P10 || kind == caic_pkg::DRV_N10) ?
		caic_pkg::MAGIC_225 : caic_pkg::MAGIC_1125;

	always_ff @(posedge clk) begin
		if (ld.scale) begin
			x_s10 <= x;
		end
		if (ld.mult) begin
			prod_s11 <= caic_pkg::MUL_W'(x_s10) * caic_pkg::MUL_W'(mag);
		end
	end

	always_comb begin
		unique case (kind)
			caic_pkg::DRV_P10, caic_pkg::DRV_N10: q = caic_pkg::Q_W'(prod_s11 >> 33);
			default:                              q = caic_pkg::Q_W'(prod_s11 >> 36);
		endcase
	end

	assign q_sat = (q > caic_pkg::Q_W'(caic_pkg::Q_MAX)) ? caic_pkg::Q_MAX :
		q[caic_pkg::CUR_W-1:0];
	assign q_mag = $signed({1'b0, q_sat});
	assign neg   = (kind == caic_pkg::DRV_N10 || kind == caic_pkg::DRV_N09);

	always_ff @(posedge clk) begin
		if (ld.drv) begin
			drive_s12 <= neg ? -q_mag : q_mag;
		end
	end

	assign drive = drive_s12;

endmodule

// ----- rtl/core/caic_checker.sv -----
`include "cable_arm_impedance_controller_assert.svh"

// Port-level checks of the impedance controller.
module caic_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [caic_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	// A waiting drive word must not change or vanish before it is taken.
	`CAIC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "drive word changed while stalled")

	// With the output free to move, every stage can advance, so input is taken.
	`CAIC_ASSERT_IMP(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with free output")

	// Motors 0 and 1 drive non-negative currents, motors 2 and 3 non-positive.
	`CAIC_ASSERT_IMP(a_drive_sign, m_axis_tvalid, !m_axis_tdata[15] && !m_axis_tdata[31] && (m_axis_tdata[47] || m_axis_tdata[47:32] == 16'h0000) && (m_axis_tdata[63] || m_axis_tdata[63:48] == 16'h0000), "drive sign out of range")

endmodule

bind cable_arm_impedance_controller caic_checker u_caic_checker (.*);

// ----- dv/tb_cable_arm_impedance_controller.sv -----
`timescale 1ns / 1ps

module tb_cable_arm_impedance_controller;

	import caic_pkg::*;

	// One Q5.10 step of drive current, in the exact internal current units
	// (3600 * 2^14). All prediction is done in these units with 64-bit integers.
	localparam longint AMP_LSB_UNITS = 58982400;

	// Field extremes of a Q7.16 input field.
	localparam logic [23:0] FIELD_MAX = 24'h7FFFFF;
	localparam logic [23:0] FIELD_MIN = 24'h800000;

	// One input word. Packed arrays put element 0 in the lowest bits, so this
	// matches the tdata layout: raw angles, then raw rates, then joint targets.
	typedef struct packed {
		logic [2:0][23:0] goal;
		logic [3:0][23:0] rate;
		logic [3:0][23:0] angle;
	} sample_t;

	// One output word: drive0 in the lowest bits.
	typedef struct packed {
		logic [3:0][15:0] drive;
	} drive_set_t;

	logic clk;
	logic arst_n;

	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // raw_angle0..3, raw_rate0..3, goal_joint0..2
	logic                  s_axis_tuser;   // zero_capture

	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // drive0, drive1, drive2, drive3

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cable_arm_impedance_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow copy of the controller state: the gain and current-limit registers
	// and the four zero offsets. It follows every accepted configuration word
	// and every capture word, exactly as the block should.
	logic [15:0] stiffness [3];
	logic [15:0] damping [3];
	logic [14:0] min_current;
	logic [14:0] max_current;
	longint      zero_offset [4];

	// Drive words still owed by the block, oldest first.
	drive_set_t expected_drive [$];
	int         drive_errors;

	// Traffic shaping, changed by the test tasks.
	bit tx_gaps_on;
	bit rx_stalls_on;
	int rx_hold_cycles;

	// Clock: 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run. The slowest legal run (every word delayed by the
	// longest sender gap and the longest receiver stall) stays far below this.
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Cable geometry: motor values to a joint value scaled by 120.
	function automatic longint joint_scaled(longint m0, longint m1, longint m2, longint m3,
			int joint);
		case (joint)
			0: return 7 * (m0 + m1 - m2 - m3);
			1: return 14 * (m2 - m3);
			default: return 28 * (m0 - m1) - 28 * (m2 - m3);
		endcase
	endfunction

	// Round a non-negative quotient to nearest, halves away from zero.
	function automatic longint round_div(longint num, longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic logic [15:0] to_q510(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// One control step: offset-corrected motor angles and rates, joint PD
	// torques, mapping back to four cable currents, coactivation base, clamp,
	// and the per-motor drive gains 0.6, 1, -1, -0.9. Everything stays exact
	// until the final Q5.10 rounding. Zero offsets must already reflect a
	// capture on this same word.
	function automatic drive_set_t predict_drive(sample_t s);
		longint ang [4];
		longint vel [4];
		longint joint_ang [3];
		longint joint_vel [3];
		longint torque [3];
		longint cable [4];
		longint target [4];
		longint lowest;
		longint base;
		longint ceiling;
		drive_set_t d;
		for (int i = 0; i < 4; i++) begin
			// Motors 0 and 1 are mounted reversed.
			if (i < 2) begin
				ang[i] = zero_offset[i] - longint'($signed(s.angle[i]));
				vel[i] = -longint'($signed(s.rate[i]));
			end else begin
				ang[i] = longint'($signed(s.angle[i])) - zero_offset[i];
				vel[i] = longint'($signed(s.rate[i]));
			end
		end
		for (int j = 0; j < 3; j++) begin
			joint_ang[j] = joint_scaled(ang[0], ang[1], ang[2], ang[3], j);
			joint_vel[j] = joint_scaled(vel[0], vel[1], vel[2], vel[3], j);
			torque[j] = longint'(stiffness[j]) *
					(joint_ang[j] - 120 * longint'($signed(s.goal[j]))) +
					longint'(damping[j]) * joint_vel[j];
		end
		cable[0] = 7 * torque[0] + 14 * torque[2];
		cable[1] = 7 * torque[0] - 14 * torque[2];
		cable[2] = -7 * torque[0] + 7 * torque[1];
		cable[3] = -7 * torque[0] - 7 * torque[1];

		lowest = cable[0];
		for (int i = 1; i < 4; i++)
			if (cable[i] < lowest)
				lowest = cable[i];
		base = lowest - longint'(min_current) * AMP_LSB_UNITS;
		if (base < 0)
			base = -base;
		ceiling = longint'(max_current) * AMP_LSB_UNITS;
		for (int i = 0; i < 4; i++) begin
			target[i] = cable[i] + base;
			if (target[i] > ceiling)
				target[i] = ceiling;
			if (target[i] < 0)
				target[i] = 0;
		end

		d.drive[0] = to_q510(round_div(3 * target[0], 5 * AMP_LSB_UNITS));
		d.drive[1] = to_q510(round_div(target[1], AMP_LSB_UNITS));
		d.drive[2] = to_q510(-round_div(target[2], AMP_LSB_UNITS));
		d.drive[3] = to_q510(-round_div(9 * target[3], 10 * AMP_LSB_UNITS));
		return d;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		case (idx)
			REG_KP0:  stiffness[0] = value;
			REG_KP1:  stiffness[1] = value;
			REG_KP2:  stiffness[2] = value;
			REG_KD0:  damping[0] = value;
			REG_KD1:  damping[1] = value;
			REG_KD2:  damping[2] = value;
			REG_MINC: min_current = value[14:0];
			REG_MAXC: max_current = value[14:0];
			default: ;
		endcase
	endfunction

	task automatic log_failure(input string msg);
		drive_errors++;
		if (drive_errors <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Monitor and checker
	// ------------------------------------------------------------------

	// Everything is sampled at the rising edge; the testbench only changes
	// inputs at the falling edge, so the values seen here are the ones the
	// block registers on this edge. The input side is handled before the output
	// side, so even a result in the same cycle as its input would find its expectation waiting.
	sample_t    seen_sample;
	drive_set_t want_drive;
	drive_set_t got_drive;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);

			if (s_axis_tvalid && s_axis_tready) begin
				seen_sample = sample_t'(s_axis_tdata);
				// A capture word loads its own raw angles first and then uses them.
				if (s_axis_tuser)
					for (int i = 0; i < 4; i++)
						zero_offset[i] = longint'($signed(seen_sample.angle[i]));
				expected_drive.push_back(predict_drive(seen_sample));
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got_drive = drive_set_t'(m_axis_tdata);
				if (expected_drive.size() == 0) begin
					log_failure($sformatf("drive word %h arrived with none expected",
							got_drive));
				end else begin
					want_drive = expected_drive.pop_front();
					for (int k = 0; k < 4; k++)
						if (got_drive.drive[k] !== want_drive.drive[k])
							log_failure($sformatf("drive%0d expected %0d got %0d",
									k, $signed(want_drive.drive[k]),
									$signed(got_drive.drive[k])));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, plus a long hold on request
	// ------------------------------------------------------------------

	// The long hold is counted here so that the sender keeps offering words
	// while the output is blocked; the pipeline fills and s_axis_tready drops.
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles != 0) begin
				m_axis_tready = 1'b0;
				repeat (rx_hold_cycles - 1) @(negedge clk);
				rx_hold_cycles = 0;
			end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 19);
				m_axis_tready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one word and hold it until the block takes it. An optional random
	// gap drops tvalid before the word is offered.
	task automatic send_sample(input sample_t s, input bit capture);
		int gap;
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = s;
		s_axis_tuser  = capture;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering words and wait until every drive word owed has come back.
	// The loop has its own bound so that a lost word ends in a failure rather
	// than waiting for the global limit.
	task automatic drain_results();
		int spins;
		spins = 0;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_drive.size() != 0 && spins < 200000) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_gains(input logic [15:0] kp0, input logic [15:0] kp1,
			input logic [15:0] kp2, input logic [15:0] kd0, input logic [15:0] kd1,
			input logic [15:0] kd2);
		write_reg(REG_KP0, kp0);
		write_reg(REG_KP1, kp1);
		write_reg(REG_KP2, kp2);
		write_reg(REG_KD0, kd0);
		write_reg(REG_KD1, kd1);
		write_reg(REG_KD2, kd2);
	endtask

	function automatic sample_t make_sample(logic [23:0] ang, logic [23:0] rate,
			logic [23:0] goal);
		sample_t s;
		for (int i = 0; i < 4; i++) begin
			s.angle[i] = ang;
			s.rate[i]  = rate;
		end
		for (int j = 0; j < 3; j++)
			s.goal[j] = goal;
		return s;
	endfunction

	// A signed field of random magnitude: the width is drawn first so that
	// small angles (where the currents land between the limits) are common,
	// while full-width values still reach every bit.
	function automatic logic [23:0] random_field();
		int          w;
		logic [31:0] r;
		w = $urandom_range(1, 24);
		r = $urandom;
		return 24'($signed(r << (32 - w)) >>> (32 - w));
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		for (int i = 0; i < 4; i++) begin
			s.angle[i] = random_field();
			s.rate[i]  = random_field();
		end
		for (int j = 0; j < 3; j++)
			s.goal[j] = random_field();
		return s;
	endfunction

	// Mostly moderate gains, sometimes the whole 16-bit range.
	function automatic logic [15:0] random_gain();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 4096));
	endfunction

	// New random settings. Bit 15 of the current limits is random too; the
	// block keeps only 15 bits. Now and then the maximum falls below the minimum.
	task automatic randomize_settings();
		logic [14:0] limit;
		write_gains(random_gain(), random_gain(), random_gain(),
				random_gain(), random_gain(), random_gain());
		write_reg(REG_MINC, {1'($urandom_range(0, 1)), 15'($urandom_range(0, 4000))});
		if ($urandom_range(0, 9) == 0)
			limit = 15'($urandom_range(0, 800));
		else
			limit = 15'($urandom_range(2000, 32767));
		write_reg(REG_MAXC, {1'($urandom_range(0, 1)), limit});
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings, no offsets: zero, both field extremes, a typical pose
	// and two alternating bit patterns.
	task automatic test_reset_settings();
		send_sample(make_sample('0, '0, '0), 1'b0);
		send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX), 1'b0);
		send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN), 1'b0);
		send_sample(make_sample(24'd6554, 24'hFFF000, 24'd3277), 1'b0);
		send_sample(sample_t'({11{24'h555555}}), 1'b0);
		send_sample(sample_t'({11{24'hAAAAAA}}), 1'b0);
	endtask

	// Capture at one angle extreme and then drive at the other, so the
	// offset-corrected angle spans its full 25-bit range in both directions.
	task automatic test_zero_capture();
		send_sample(make_sample(FIELD_MIN, 24'd100, '0), 1'b1);
		send_sample(make_sample(FIELD_MAX, 24'd100, '0), 1'b0);
		send_sample(make_sample(FIELD_MAX, '0, 24'd500), 1'b1);
		send_sample(make_sample(FIELD_MIN, '0, 24'd500), 1'b0);
		// Back to a zero reference for the tests that follow.
		send_sample(make_sample('0, '0, '0), 1'b1);
	endtask

	// Only joint 2 acts, with unit stiffness. A target of 480 LSB puts the base, and
	// with it the currents of motors 2 and 3, half a Q5.10 step off a whole step, so
	// the rounding of motor 2 lands on a tie, once for each sign of the torque.
	task automatic test_rounding_ties();
		sample_t s;
		drain_results();
		write_gains('0, '0, 16'd256, '0, '0, '0);
		s = make_sample('0, '0, '0);
		s.goal[2] = -24'sd480;
		send_sample(s, 1'b0);
		s.goal[2] = 24'sd480;
		send_sample(s, 1'b0);
	endtask

	// Minimum above maximum (every current clamps to the maximum), a zero
	// maximum, and the widest window. Writes with bit 15 set check the masking.
	task automatic test_current_limits();
		drain_results();
		write_gains(16'd2304, 16'd1536, 16'd26, 16'd410, 16'd307, 16'd205);
		write_reg(REG_MINC, 16'hFFFF);
		write_reg(REG_MAXC, 16'd100);
		send_sample(make_sample(24'd6554, 24'd1000, '0), 1'b0);
		drain_results();
		write_reg(REG_MAXC, 16'h8000);
		send_sample(make_sample(24'hFF0000, 24'd1000, 24'd300), 1'b0);
		drain_results();
		write_reg(REG_MINC, 16'h8000);
		write_reg(REG_MAXC, 16'hFFFF);
		send_sample(make_sample(FIELD_MAX, FIELD_MIN, FIELD_MIN), 1'b0);
	endtask

	// All gains at full scale and all gains at zero.
	task automatic test_gain_extremes();
		drain_results();
		write_gains('1, '1, '1, '1, '1, '1);
		send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MIN), 1'b0);
		send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MAX), 1'b0);
		send_sample(make_sample(24'd6554, 24'hFFE000, 24'd100), 1'b0);
		drain_results();
		write_gains('0, '0, '0, '0, '0, '0);
		send_sample(make_sample(FIELD_MAX, FIELD_MIN, FIELD_MAX), 1'b0);
	endtask

	// The receiver blocks for a long stretch while the sender keeps offering
	// back-to-back words, so the pipeline fills and must stall its input.
	task automatic test_output_hold();
		drain_results();
		randomize_settings();
		tx_gaps_on = 1'b0;
		rx_hold_cycles = 150;
		for (int n = 0; n < 60; n++)
			send_sample(random_sample(), $urandom_range(0, 11) == 0);
		tx_gaps_on = 1'b1;
	endtask

	// The sender stops until every owed word has come back, then resumes.
	task automatic test_input_pause();
		for (int n = 0; n < 40; n++)
			send_sample(random_sample(), $urandom_range(0, 11) == 0);
		drain_results();
		for (int n = 0; n < 40; n++)
			send_sample(random_sample(), $urandom_range(0, 11) == 0);
	endtask

	// Random words under several random settings. The last phase runs with
	// no gaps and no stalls at full rate.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			drain_results();
			randomize_settings();
			tx_gaps_on   = (phase < 5);
			rx_stalls_on = (phase < 5);
			for (int n = 0; n < 280; n++)
				send_sample(random_sample(), $urandom_range(0, 11) == 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = 1'b0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_KP0;
		cfg_data       = '0;
		drive_errors   = 0;
		rx_hold_cycles = 0;
		tx_gaps_on     = 1'b1;
		rx_stalls_on   = 1'b1;

		// Shadow state after reset.
		stiffness[0] = KP0_RST;
		stiffness[1] = KP1_RST;
		stiffness[2] = KP2_RST;
		damping[0]   = KD0_RST;
		damping[1]   = KD1_RST;
		damping[2]   = KD2_RST;
		min_current  = MINC_RST;
		max_current  = MAXC_RST;
		for (int i = 0; i < 4; i++)
			zero_offset[i] = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_settings();
		test_zero_capture();
		test_rounding_ties();
		test_current_limits();
		test_gain_extremes();
		test_output_hold();
		test_input_pause();
		test_random_traffic();

		// Everything sent: wait for the last words, then keep watching the output
		// to catch any extra word the block might still produce.
		drain_results();
		repeat (24) @(posedge clk);

		if (drive_errors == 0 && expected_drive.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/caic_pkg.sv
rtl/core/caic_joint_lane.sv
rtl/core/caic_motor_lane.sv
rtl/core/cable_arm_impedance_controller.sv
rtl/core/caic_checker.sv
dv/tb_cable_arm_impedance_controller.sv
